FILE: src/dgmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgmc_pkg
// Shared types and constants of the debounced gate motor controller.
// ----------------------------------------------------------------------------
package dgmc_pkg;

    localparam int QUEUE_DEPTH = 5;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int MID_DEPTH   = 2;
    localparam int MID_IDX_W   = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
    localparam int MID_CNT_W   = $clog2(MID_DEPTH + 1);

    localparam logic [7:0] STABLE_COUNT_RESET = 8'd5;

    localparam logic EV_OPEN  = 1'b0;
    localparam logic EV_CLOSE = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OPENING = 2'd1,
        MODE_CLOSING = 2'd2
    } gate_mode_t;

    typedef struct packed {
        logic open_ev;
        logic close_ev;
        logic open_lim;
        logic close_lim;
    } mid_item_t;

endpackage
`default_nettype wire

FILE: src/dgmc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgmc_front
// Button debouncers and the stable count register; turns each sample tick
// into a classified item with open and close events.
// ----------------------------------------------------------------------------
module dgmc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [7:0]         cfg_write_data,
    input  wire logic               accept,
    input  wire logic               open_button_level,
    input  wire logic               close_button_level,
    input  wire logic               open_limit_level,
    input  wire logic               close_limit_level,
    output dgmc_pkg::mid_item_t     item
);
    import dgmc_pkg::*;

    typedef struct packed {
        logic       waits_low;
        logic [7:0] high_run;
        logic [7:0] low_run;
    } deb_state_t;

    typedef struct packed {
        deb_state_t st;
        logic       press;
    } deb_result_t;

    logic [7:0]  stable_count_reg;
    deb_state_t  open_reg, open_next;
    deb_state_t  close_reg, close_next;
    deb_result_t open_res, close_res;

    function automatic logic [7:0] run_inc(input logic [7:0] run, input logic [7:0] sc);
        return (run >= sc) ? sc : run + 8'd1;
    endfunction

    function automatic deb_result_t deb_step(input deb_state_t s, input logic level,
                                             input logic [7:0] sc);
        deb_result_t r;
        r.st    = s;
        r.press = 1'b0;
        if (!level) begin
            r.st.low_run  = run_inc(s.low_run, sc);
            r.st.high_run = 8'd0;
        end
        else begin
            r.st.high_run = run_inc(s.high_run, sc);
            r.st.low_run  = 8'd0;
        end
        if (!s.waits_low) begin
            if (r.st.high_run >= sc)
                r.st.waits_low = 1'b1;
        end
        else if (r.st.low_run >= sc) begin
            r.st.waits_low = 1'b0;
            r.press        = 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        open_res   = deb_step(open_reg, open_button_level, stable_count_reg);
        close_res  = deb_step(close_reg, close_button_level, stable_count_reg);
        open_next  = open_res.st;
        close_next = close_res.st;
        item.open_ev   = open_res.press;
        item.close_ev  = close_res.press;
        item.open_lim  = open_limit_level;
        item.close_lim = close_limit_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_count_reg <= STABLE_COUNT_RESET;
            open_reg         <= '0;
            close_reg        <= '0;
        end
        else
        begin
            if (cfg_write_en)
                stable_count_reg <= cfg_write_data;
            if (accept)
            begin
                open_reg  <= open_next;
                close_reg <= close_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/dgmc_mid_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgmc_mid_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dgmc_mid_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  dgmc_pkg::mid_item_t     push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    empty,
    output dgmc_pkg::mid_item_t     head_item
);
    import dgmc_pkg::*;

    localparam logic [MID_CNT_W-1:0] DEPTH_C = MID_CNT_W'(MID_DEPTH);

    mid_item_t              mem_reg [MID_DEPTH];
    logic [MID_IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [MID_IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [MID_CNT_W-1:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == MID_IDX_W'(MID_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == MID_IDX_W'(MID_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

FILE: src/dgmc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgmc_back
// Event queue and motor state machine; executes one classified item per
// cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module dgmc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_avail,
    input  dgmc_pkg::mid_item_t     item,
    output logic                    item_take,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    drive_a,
    output logic                    drive_b,
    output logic [1:0]              gate_mode,
    output logic                    event_dropped,
    output logic [2:0]              pending_events
);
    import dgmc_pkg::*;

    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);

    gate_mode_t         motion_reg, motion_next;
    logic               store_reg  [QUEUE_DEPTH];
    logic               store_next [QUEUE_DEPTH];
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped;
    logic               ev;
    logic               out_valid_reg;
    logic               drive_a_reg, drive_b_reg, dropped_reg;
    logic [1:0]         mode_reg;
    logic [2:0]         pending_reg;

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= DEPTH_S)
            s = s - DEPTH_S;
        return s[IDX_W-1:0];
    endfunction

    assign item_take = item_avail && (!out_valid_reg || !out_stall);

    always_comb
    begin
        motion_next = motion_reg;
        store_next  = store_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        dropped     = 1'b0;
        ev          = EV_OPEN;
        if (item_take)
        begin
            case (motion_reg)
                MODE_OPENING: if (!item.open_lim)  motion_next = MODE_IDLE;
                MODE_CLOSING: if (!item.close_lim) motion_next = MODE_IDLE;
                default:      motion_next = motion_reg;
            endcase
            if (item.open_ev)
            begin
                if (count_next < DEPTH_C)
                begin
                    store_next[wrap(head_reg, count_next)] = EV_OPEN;
                    count_next = count_next + 1'b1;
                end
                else
                    dropped = 1'b1;
            end
            if (item.close_ev)
            begin
                if (count_next < DEPTH_C)
                begin
                    store_next[wrap(head_reg, count_next)] = EV_CLOSE;
                    count_next = count_next + 1'b1;
                end
                else
                    dropped = 1'b1;
            end
            if (motion_next == MODE_IDLE && count_next != '0)
            begin
                ev         = store_next[head_reg];
                head_next  = wrap(head_reg, CNT_W'(1));
                count_next = count_next - 1'b1;
                if (ev == EV_OPEN && item.open_lim)
                    motion_next = MODE_OPENING;
                else if (ev == EV_CLOSE && item.close_lim)
                    motion_next = MODE_CLOSING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg    <= MODE_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            motion_reg <= motion_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            if (item_take)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        if (item_take)
        begin
            drive_a_reg <= (motion_next == MODE_CLOSING);
            drive_b_reg <= (motion_next == MODE_OPENING);
            mode_reg    <= motion_next;
            dropped_reg <= dropped;
            pending_reg <= 3'(count_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_a        = drive_a_reg;
    assign drive_b        = drive_b_reg;
    assign gate_mode      = mode_reg;
    assign event_dropped  = dropped_reg;
    assign pending_events = pending_reg;

endmodule
`default_nettype wire

FILE: src/debounced_gate_motor_controller_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_gate_motor_controller_unit
// Gate motor controller with two debounced push buttons and two limit
// switches.
//
// Input channel (in_valid / in_stall): one sample tick of both buttons and
// both limit switches per item. Output channel (out_valid / out_stall): one
// result per item with the motor drive lines, the gate mode, the drop flag
// and the number of queued button events.
// Config: cfg_write_en writes cfg_write_data into stable_count.
//
// Throughput is one item per cycle while out_stall stays low. An item
// accepted at the input is debounced into a two-entry queue, taken from
// it by the back end and registered at the output. The back end executes
// one item per cycle, while the output is not stalled, against the event
// queue and motor state.
// When out_stall holds, the output register keeps its result, the middle
// queue fills and in_stall rises once it holds two items.
// Reset clears the debouncers, the event queue, the motor state and both
// channels, and sets stable_count to 5.
// ----------------------------------------------------------------------------
module debounced_gate_motor_controller_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [7:0]  cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        open_button_level,
    input  wire logic        close_button_level,
    input  wire logic        open_limit_level,
    input  wire logic        close_limit_level,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             drive_a,
    output logic             drive_b,
    output logic [1:0]       gate_mode,
    output logic             event_dropped,
    output logic [2:0]       pending_events
);
    import dgmc_pkg::*;

    mid_item_t front_item;
    mid_item_t head_item;
    logic      accept;
    logic      mid_full;
    logic      mid_empty;
    logic      take;

    assign in_stall = mid_full;
    assign accept   = in_valid && !mid_full;

    dgmc_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data),
        .accept             (accept),
        .open_button_level  (open_button_level),
        .close_button_level (close_button_level),
        .open_limit_level   (open_limit_level),
        .close_limit_level  (close_limit_level),
        .item               (front_item)
    );

    dgmc_mid_fifo u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .full      (mid_full),
        .pop       (take),
        .empty     (mid_empty),
        .head_item (head_item)
    );

    dgmc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_avail     (!mid_empty),
        .item           (head_item),
        .item_take      (take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_a        (drive_a),
        .drive_b        (drive_b),
        .gate_mode      (gate_mode),
        .event_dropped  (event_dropped),
        .pending_events (pending_events)
    );

endmodule
`default_nettype wire

FILE: src/dgmc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgmc_checker
// Port-level checks of the gate motor controller, bound to the top level.
// ----------------------------------------------------------------------------
module dgmc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        drive_a,
    input wire logic        drive_b,
    input wire logic [1:0]  gate_mode,
    input wire logic        event_dropped,
    input wire logic [2:0]  pending_events
);
    import dgmc_pkg::*;

    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(drive_a && drive_b))
        else $error("both drive lines active");

    a_drive_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_a == (gate_mode == MODE_CLOSING)) &&
                      (drive_b == (gate_mode == MODE_OPENING)))
        else $error("drive lines disagree with gate mode");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_events <= 3'(QUEUE_DEPTH)))
        else $error("pending events beyond queue depth");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_a) && $stable(drive_b) &&
            $stable(gate_mode) && $stable(event_dropped) && $stable(pending_events))
        else $error("stalled result changed");

endmodule

bind debounced_gate_motor_controller_unit dgmc_checker u_dgmc_checker (.*);
`default_nettype wire
